/* rtl/q_learning_table_update_macros.svh */
// Assertion helpers, included by the top-level RTL.
`ifndef Q_LEARNING_TABLE_UPDATE_MACROS_SVH
`define Q_LEARNING_TABLE_UPDATE_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define QLTU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("qltu assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define QLTU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("qltu assertion failed");

`endif

/* rtl/qltu_pkg.sv */
package qltu_pkg;

  // Table geometry
  localparam int unsigned NUM_STATES  = 256;
  localparam int unsigned NUM_ACTIONS = 8;
  localparam int unsigned STATE_W     = $clog2(NUM_STATES);
  localparam int unsigned ACT_W       = $clog2(NUM_ACTIONS);

  // Data widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned RATE_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef value_t [NUM_ACTIONS-1:0]  row_t;

  // Constants
  localparam value_t              VALUE_ONE       = 32'sd65536;
  localparam logic [RATE_W:0]     RATE_ONE        = 17'd65536;
  localparam logic [RATE_W-1:0]   LEARN_RATE_RST  = 16'd19661;
  localparam logic [RATE_W-1:0]   DISCOUNT_RST    = 16'd58982;
  localparam row_t                RESET_ROW       = {NUM_ACTIONS{VALUE_ONE}};

  // Operation codes
  localparam logic OP_LEARN = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT   = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic rd_cur;
    logic scan_en;
    logic prod_en;
    logic tgt_en;
    logic mul_en;
    logic sum_en;
    logic wr_en;
    logic q_done;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic is_query;
  } sts_t;

endpackage

/* rtl/qltu_ctrl.sv */
module qltu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  qltu_pkg::sts_t  sts_i,
  output qltu_pkg::cmd_t  cmd_o
);
  import qltu_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_RDCUR = 4'd3;
  localparam logic [3:0] S_TGT   = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_WRITE = 4'd7;
  localparam logic [3:0] S_QDONE = 4'd8;

  logic [3:0] state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.is_query ? S_QDONE : S_RDCUR;
        end
      end
      S_RDCUR: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_cur  = 1'b1;
        cmd_o.prod_en = 1'b1;
        state_d       = S_TGT;
      end
      S_TGT: begin
        cmd_o.tgt_en = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_en = 1'b1;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        cmd_o.wr_en = 1'b1;
        state_d     = S_IDLE;
      end
      S_QDONE: begin
        cmd_o.q_done = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* rtl/qltu_dp.sv */
module qltu_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qltu_pkg::cmd_t                      cmd_i,
  output qltu_pkg::sts_t                      sts_o,
  input  logic                                operation_i,
  input  logic [qltu_pkg::STATE_W-1:0]        state_index_i,
  input  logic [qltu_pkg::STATE_W-1:0]        next_state_index_i,
  input  logic [qltu_pkg::ACT_W-1:0]          action_index_i,
  input  logic signed [qltu_pkg::VALUE_W-1:0] reward_value_i,
  input  logic                                cfg_we_i,
  input  logic [qltu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qltu_pkg::RATE_W-1:0]         cfg_wdata_i,
  output logic                                done_o,
  output logic [qltu_pkg::ACT_W-1:0]          best_action_o,
  output logic signed [qltu_pkg::VALUE_W-1:0] new_value_o
);
  import qltu_pkg::*;

  // Config registers
  logic [RATE_W-1:0] learn_rate_q, discount_q;

  // Latched item
  logic               op_q;
  logic [STATE_W-1:0] s_q, ns_q;
  logic [ACT_W-1:0]   act_q;
  value_t             reward_q;

  // Row store
  row_t               row_mem [NUM_STATES];
  logic [NUM_STATES-1:0] row_valid_q;
  row_t               rdata_q;
  logic               rvalid_q;
  logic [STATE_W-1:0] rd_addr;
  row_t               row_sel;
  row_t               wr_row;

  // Scan
  logic [ACT_W-1:0] scan_cnt_q, best_idx_q;
  value_t           best_val_q;
  value_t           scan_cur;

  // Arithmetic
  logic signed [48:0] prod_q;
  logic signed [49:0] prod_rnd;
  logic signed [33:0] target_q, target_d;
  logic [RATE_W:0]    keep_rate;
  value_t             cur_val;
  logic signed [49:0] p_keep_q;
  logic signed [50:0] p_learn_q;
  logic signed [51:0] acc_q, acc_rnd;
  logic signed [35:0] nv_wide;
  value_t             nv_sat;

  // Config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_rate_q <= LEARN_RATE_RST;
      discount_q   <= DISCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEARN_RATE: learn_rate_q <= cfg_wdata_i;
        REG_DISCOUNT:   discount_q   <= cfg_wdata_i;
        default:        ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q     <= operation_i;
      s_q      <= state_index_i;
      ns_q     <= next_state_index_i;
      act_q    <= action_index_i;
      reward_q <= reward_value_i;
    end
  end

  // Row read address: query and current row use state, first learn read uses next state
  assign rd_addr = (cmd_i.rd_cur || (op_q == OP_QUERY)) ? s_q : ns_q;

  // A row never written reads as all 1.0
  assign row_sel = rvalid_q ? rdata_q : RESET_ROW;

  // Row memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= row_mem[rd_addr];
    end
    if (cmd_i.wr_en) begin
      row_mem[s_q] <= wr_row;
    end
  end

  // Row valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rvalid_q <= row_valid_q[rd_addr];
      end
      if (cmd_i.wr_en) begin
        row_valid_q[s_q] <= 1'b1;
      end
    end
  end

  // Max scan, one entry per cycle, lowest index wins ties
  assign scan_cur = $signed(row_sel[scan_cnt_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.load_item) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_en) begin
      scan_cnt_q <= scan_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_en) begin
      if ((scan_cnt_q == '0) || (scan_cur > best_val_q)) begin
        best_val_q <= scan_cur;
        best_idx_q <= scan_cnt_q;
      end
    end
  end

  assign sts_o.scan_last = (scan_cnt_q == ACT_W'(NUM_ACTIONS - 1));
  assign sts_o.is_query  = (op_q == OP_QUERY);

  // target = reward + round(discount * max)
  assign prod_rnd = $signed({prod_q[48], prod_q}) + 50'sd32768;
  assign target_d = $signed({{2{reward_q[VALUE_W-1]}}, reward_q}) + $signed(prod_rnd[49:16]);

  // acc = (1 - lr) * Q + lr * target
  assign keep_rate = RATE_ONE - {1'b0, learn_rate_q};
  assign cur_val   = $signed(row_sel[act_q]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q <= $signed({1'b0, discount_q}) * best_val_q;
    end
    if (cmd_i.tgt_en) begin
      target_q <= target_d;
    end
    if (cmd_i.mul_en) begin
      p_keep_q  <= $signed({1'b0, keep_rate}) * cur_val;
      p_learn_q <= $signed({1'b0, learn_rate_q}) * target_q;
    end
    if (cmd_i.sum_en) begin
      acc_q <= $signed({{2{p_keep_q[49]}}, p_keep_q}) + $signed({p_learn_q[50], p_learn_q});
    end
  end

  // Round and saturate to 32 bits
  assign acc_rnd = acc_q + 52'sd32768;
  assign nv_wide = $signed(acc_rnd[51:16]);

  always_comb begin
    if ((nv_wide[35:31] == 5'b00000) || (nv_wide[35:31] == 5'b11111)) begin
      nv_sat = $signed(nv_wide[31:0]);
    end else if (nv_wide[35]) begin
      nv_sat = 32'sh8000_0000;
    end else begin
      nv_sat = 32'sh7FFF_FFFF;
    end
  end

  // Write-back row with the updated entry
  always_comb begin
    wr_row        = row_sel;
    wr_row[act_q] = nv_sat;
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= cmd_i.wr_en || cmd_i.q_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      best_action_o <= '0;
      new_value_o   <= nv_sat;
    end else if (cmd_i.q_done) begin
      best_action_o <= best_idx_q;
      new_value_o   <= '0;
    end
  end

endmodule

/* rtl/q_learning_table_update.sv */
// Channel   Direction  Handshake            Payload
// item      in         start & !busy        operation_i, state_index_i, next_state_index_i,
//                                           action_index_i, reward_value_i
// result    out        done_o (one cycle)   best_action_o, new_value_o
// config    in         cfg_we_i             cfg_index_i, cfg_wdata_i
//
// A query keeps busy high for a row read, a max scan of the registered row's eight
// entries, and a final state that loads the result. A learn item runs the row read
// and scan, then a state that reads the current row while forming discount * max,
// then target add, two parallel multiplies, sum and write-back, each in its own state.
// The strobe comes in the first cycle with busy low; a new item may start then.
// Reset clears the row valid bits so every entry reads 1.0; results take no acknowledge.
`include "q_learning_table_update_macros.svh"

module q_learning_table_update (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation_i,
  input  logic [qltu_pkg::STATE_W-1:0]        state_index_i,
  input  logic [qltu_pkg::STATE_W-1:0]        next_state_index_i,
  input  logic [qltu_pkg::ACT_W-1:0]          action_index_i,
  input  logic signed [qltu_pkg::VALUE_W-1:0] reward_value_i,
  input  logic                                cfg_we_i,
  input  logic [qltu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qltu_pkg::RATE_W-1:0]         cfg_wdata_i,
  output logic                                done_o,
  output logic [qltu_pkg::ACT_W-1:0]          best_action_o,
  output logic signed [qltu_pkg::VALUE_W-1:0] new_value_o
);
  import qltu_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  qltu_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  // Table, scan and update arithmetic
  qltu_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .operation_i        (operation_i),
    .state_index_i      (state_index_i),
    .next_state_index_i (next_state_index_i),
    .action_index_i     (action_index_i),
    .reward_value_i     (reward_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .best_action_o      (best_action_o),
    .new_value_o        (new_value_o)
  );

  // An accepted item keeps the block busy in the next cycle
  `QLTU_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  // The result strobe lasts one cycle
  `QLTU_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  // A result is shown only once the sequencer is back to idle
  `QLTU_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  // Busy rises only from an accepted item
  `QLTU_ASSERT_IMP(a_busy_cause, clk_i, rst_ni, $rose(busy), $past(start && !busy))

endmodule
